### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Both expect clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CBFD_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("cbfd assertion failed");

// Next-cycle implication.
`define CBFD_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("cbfd assertion failed");

`endif

### rtl/core/cbfd_pkg.sv
// ----------------------------------------------------------------------------
// cbfd_pkg
// Types and constants of the cubic Bezier forward difference stepper.
// ----------------------------------------------------------------------------
package cbfd_pkg;

  localparam int COORD_W   = 32;
  localparam int DIFF_W    = 48;
  localparam int STEP_W    = 16;
  localparam int FUNC_W    = 2;
  localparam int PT_W      = 2;
  localparam int NUM_AXES  = 3;
  localparam int NUM_PTS   = 4;
  localparam int AXIS_W    = 2;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int DIFF_FRAC_BITS_DEF  = 32;

  // Basis coefficients of 32-bit points stay below 2^35 in magnitude; six
  // times the cubic term stays below 2^38.
  localparam int COEF_W = 40;
  localparam int MAG_W  = 39;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_NEXT  = 2'd2
  } func_e;

  // Division terms in the order they are evaluated for each axis.
  typedef enum logic [2:0] {
    TERM_A  = 3'd0,
    TERM_A6 = 3'd1,
    TERM_B  = 3'd2,
    TERM_B2 = 3'd3,
    TERM_C  = 3'd4
  } term_e;

  typedef struct packed {
    logic              load_cp;
    logic              start_setup;
    logic              next_step;
    logic              mul_sq;
    logic              mul_cube;
    logic              div_load;
    logic              div_step;
    logic              div_wb;
    logic              emit;
    logic [AXIS_W-1:0] axis;
    term_e             term;
  } cbfd_cmd_t;

  typedef struct packed {
    logic long_curve;
  } cbfd_stat_t;

endpackage

### rtl/core/cbfd_if.sv
// ----------------------------------------------------------------------------
// cbfd_in_if / cbfd_out_if
// Valid/ready channels carrying curve commands and curve points.
// ----------------------------------------------------------------------------
interface cbfd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [1:0]  point_index;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;

  modport source (output valid, func, point_index, coord_x, coord_y, coord_z,
                  input ready);
  modport sink   (input valid, func, point_index, coord_x, coord_y, coord_z,
                  output ready);
endinterface

interface cbfd_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic        curve_done;

  modport source (output valid, pos_x, pos_y, pos_z, curve_done, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, curve_done, output ready);
endinterface

### rtl/core/cubic_bezier_forward_difference.sv
// ----------------------------------------------------------------------------
// cubic_bezier_forward_difference
// Three-axis cubic Bezier curve stepper using forward differencing.
// ----------------------------------------------------------------------------
// Usage: write steps_wanted through cfg_we_i/cfg_wdata_i while the block is
// idle. Commands arrive on in_i; load transactions store a control point and
// produce nothing. Start and next transactions each produce one transaction
// on out_o carrying the current point and the done flag.
// A next's point is registered when it is accepted and presented on the following
// cycle; the parallel 48-bit adds for all three axes are done in the accepting cycle.
// A start with more than one step runs the square and cube multiplies, then
// fifteen divisions on one shared restoring divider, each a load, a run of
// MAG_W + shift quotient bits and a write-back, then registers the point.
// A start with one step or fewer answers in the cycle after acceptance.
// A new transaction is taken when the block is idle and the output register
// is empty or being drained in the same cycle; a stalled receiver holds the
// result and blocks further input.
// Reset clears all control points, differences, the step count and
// steps_wanted at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module cubic_bezier_forward_difference
  import cbfd_pkg::*;
#(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int DIFF_FRAC_BITS  = DIFF_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [STEP_W-1:0] cfg_wdata_i,
  cbfd_in_if.sink           in_i,
  cbfd_out_if.source        out_o
);

  cbfd_cmd_t  cmd;
  cbfd_stat_t stat;

  cbfd_ctrl #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .DIFF_FRAC_BITS  (DIFF_FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .func_i      (in_i.func),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cbfd_dp #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .DIFF_FRAC_BITS  (DIFF_FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .point_index_i (in_i.point_index),
    .coord_x_i     (in_i.coord_x),
    .coord_y_i     (in_i.coord_y),
    .coord_z_i     (in_i.coord_z),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .pos_x_o       (out_o.pos_x),
    .pos_y_o       (out_o.pos_y),
    .pos_z_o       (out_o.pos_z),
    .curve_done_o  (out_o.curve_done)
  );

endmodule

### rtl/core/cbfd_ctrl.sv
// ----------------------------------------------------------------------------
// cbfd_ctrl
// Sequencer: handshakes, setup multiplies and the shared serial divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbfd_ctrl
  import cbfd_pkg::*;
#(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int DIFF_FRAC_BITS  = DIFF_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  cbfd_stat_t        stat_i,
  output cbfd_cmd_t         cmd_o
);

  localparam int SHIFT_UP = (DIFF_FRAC_BITS >= COORD_FRAC_BITS) ?
                            DIFF_FRAC_BITS - COORD_FRAC_BITS : 0;
  localparam int DIV_N = MAG_W + SHIFT_UP;
  localparam int CNT_W = $clog2(DIV_N);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_N - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQ, ST_CUBE, ST_DLOAD, ST_DRUN, ST_DWB, ST_EMIT
  } state_e;

  state_e            state_q;
  logic [AXIS_W-1:0] axis_q;
  term_e             term_q;
  logic [CNT_W-1:0]  bit_q;
  logic              out_valid_q;
  logic              accept;
  logic              is_load, is_start, is_next;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    is_load  = 1'b0;
    is_start = 1'b0;
    is_next  = 1'b0;
    unique case (func_i)
      FUNC_LOAD:  is_load  = 1'b1;
      FUNC_START: is_start = 1'b1;
      FUNC_NEXT:  is_next  = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    cmd_o.load_cp     = accept && is_load;
    cmd_o.start_setup = accept && is_start;
    cmd_o.next_step   = accept && is_next;
    cmd_o.mul_sq      = (state_q == ST_SQ);
    cmd_o.mul_cube    = (state_q == ST_CUBE);
    cmd_o.div_load    = (state_q == ST_DLOAD);
    cmd_o.div_step    = (state_q == ST_DRUN);
    cmd_o.div_wb      = (state_q == ST_DWB);
    cmd_o.emit        = (accept && (is_next || (is_start && !stat_i.long_curve))) ||
                        (state_q == ST_EMIT);
    cmd_o.axis        = axis_q;
    cmd_o.term        = term_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= '0;
      term_q      <= TERM_A;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && is_start && stat_i.long_curve) begin
            state_q <= ST_SQ;
            axis_q  <= '0;
            term_q  <= TERM_A;
          end
        end
        ST_SQ:    state_q <= ST_CUBE;
        ST_CUBE:  state_q <= ST_DLOAD;
        ST_DLOAD: begin
          bit_q   <= '0;
          state_q <= ST_DRUN;
        end
        ST_DRUN: begin
          bit_q <= bit_q + 1'b1;
          if (bit_q == CNT_LAST) begin
            state_q <= ST_DWB;
          end
        end
        ST_DWB: begin
          if (term_q == TERM_C) begin
            term_q <= TERM_A;
            if (axis_q == AXIS_W'(NUM_AXES - 1)) begin
              state_q <= ST_EMIT;
            end else begin
              axis_q  <= axis_q + 1'b1;
              state_q <= ST_DLOAD;
            end
          end else begin
            term_q  <= term_e'(term_q + 3'd1);
            state_q <= ST_DLOAD;
          end
        end
        ST_EMIT:  state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  `CBFD_ASSERT_IMP(a_no_overwrite, cmd_o.emit, !out_valid_q || out_ready_i)
  `CBFD_ASSERT_NXT(a_long_start, accept && is_start && stat_i.long_curve, state_q == ST_SQ)
  `CBFD_ASSERT_NXT(a_div_end, (state_q == ST_DRUN) && (bit_q == CNT_LAST), state_q == ST_DWB)

endmodule

### rtl/core/cbfd_dp.sv
// ----------------------------------------------------------------------------
// cbfd_dp
// Datapath: control points, difference registers, setup arithmetic, divider.
// ----------------------------------------------------------------------------
module cbfd_dp
  import cbfd_pkg::*;
#(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int DIFF_FRAC_BITS  = DIFF_FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [STEP_W-1:0]         cfg_wdata_i,
  input  logic [PT_W-1:0]           point_index_i,
  input  logic signed [COORD_W-1:0] coord_x_i,
  input  logic signed [COORD_W-1:0] coord_y_i,
  input  logic signed [COORD_W-1:0] coord_z_i,
  input  cbfd_cmd_t                 cmd_i,
  output cbfd_stat_t                stat_o,
  output logic signed [COORD_W-1:0] pos_x_o,
  output logic signed [COORD_W-1:0] pos_y_o,
  output logic signed [COORD_W-1:0] pos_z_o,
  output logic                      curve_done_o
);

  localparam int SHIFT_UP   = (DIFF_FRAC_BITS >= COORD_FRAC_BITS) ?
                              DIFF_FRAC_BITS - COORD_FRAC_BITS : 0;
  localparam int SHIFT_DOWN = (COORD_FRAC_BITS > DIFF_FRAC_BITS) ?
                              COORD_FRAC_BITS - DIFF_FRAC_BITS : 0;
  localparam int DVD_W = MAG_W + SHIFT_UP;
  localparam int DSR_W = DIFF_W + SHIFT_DOWN;
  localparam int REM_W = DSR_W + 1;

  logic [STEP_W-1:0]          steps_q;
  logic [STEP_W-1:0]          step_q;
  logic signed [COORD_W-1:0]  cp_q   [NUM_PTS][NUM_AXES];
  logic signed [COEF_W-1:0]   ca_q   [NUM_AXES];
  logic signed [COEF_W-1:0]   cb_q   [NUM_AXES];
  logic signed [COEF_W-1:0]   cc_q   [NUM_AXES];
  logic [DIFF_W-1:0]          cur_q  [NUM_AXES];
  logic [DIFF_W-1:0]          d1_q   [NUM_AXES];
  logic [DIFF_W-1:0]          d2_q   [NUM_AXES];
  logic [DIFF_W-1:0]          d3_q   [NUM_AXES];
  logic [STEP_W-1:0]          m_q;
  logic [2*STEP_W-1:0]        m2_q;
  logic [DIFF_W-1:0]          m3_q;
  logic [DVD_W-1:0]           dvd_q;
  logic [DSR_W-1:0]           dsr_q;
  logic [REM_W-1:0]           rem_q;
  logic [DIFF_W-1:0]          quo_q;
  logic                       neg_q;

  logic [DIFF_W-1:0]          p0_diff [NUM_AXES];
  logic [DIFF_W-1:0]          cur_nx  [NUM_AXES];
  logic [DIFF_W-1:0]          emit_pt [NUM_AXES];
  logic [STEP_W-1:0]          step_sat;
  logic [STEP_W-1:0]          emit_step;
  logic signed [COEF_W-1:0]   numer;
  logic [COEF_W-1:0]          numer_mag;
  logic [REM_W-1:0]           trial;
  logic                       trial_ok;
  logic [DIFF_W-1:0]          quo_s;

  function automatic logic [COORD_W-1:0] to_coord(logic [DIFF_W-1:0] v);
    logic signed [63:0] w;
    w = 64'(signed'(v));
    w = (w >>> SHIFT_UP) <<< SHIFT_DOWN;
    return w[COORD_W-1:0];
  endfunction

  assign stat_o.long_curve = (steps_q > STEP_W'(1));

  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      logic signed [63:0] w;
      w           = 64'(cp_q[0][ax]);
      w           = (w <<< SHIFT_UP) >>> SHIFT_DOWN;
      p0_diff[ax] = w[DIFF_W-1:0];
      cur_nx[ax]  = cur_q[ax] + d1_q[ax];
      if (cmd_i.next_step) begin
        emit_pt[ax] = cur_nx[ax];
      end else begin
        emit_pt[ax] = cur_q[ax];
      end
    end
    step_sat = (step_q == '1) ? step_q : step_q + 1'b1;
    priority if (cmd_i.next_step) begin
      emit_step = step_sat;
    end else if (cmd_i.start_setup) begin
      emit_step = '0;
    end else begin
      emit_step = step_q;
    end
  end

  // Numerator of the term under division, trial subtraction and signed quotient.
  always_comb begin
    unique case (cmd_i.term)
      TERM_A:  numer = ca_q[cmd_i.axis];
      TERM_A6: numer = (ca_q[cmd_i.axis] <<< 2) + (ca_q[cmd_i.axis] <<< 1);
      TERM_B:  numer = cb_q[cmd_i.axis];
      TERM_B2: numer = cb_q[cmd_i.axis] <<< 1;
      TERM_C:  numer = cc_q[cmd_i.axis];
      default: numer = '0;
    endcase
    numer_mag = numer[COEF_W-1] ? COEF_W'(-numer) : COEF_W'(numer);
    trial     = {rem_q[REM_W-2:0], dvd_q[DVD_W-1]};
    trial_ok  = (trial >= REM_W'(dsr_q));
    quo_s     = neg_q ? DIFF_W'(-quo_q) : quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= '0;
      step_q  <= '0;
      for (int p = 0; p < NUM_PTS; p++) begin
        for (int ax = 0; ax < NUM_AXES; ax++) begin
          cp_q[p][ax] <= '0;
        end
      end
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        cur_q[ax] <= '0;
        d1_q[ax]  <= '0;
        d2_q[ax]  <= '0;
        d3_q[ax]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        steps_q <= cfg_wdata_i;
      end
      if (cmd_i.load_cp) begin
        cp_q[point_index_i][0] <= coord_x_i;
        cp_q[point_index_i][1] <= coord_y_i;
        cp_q[point_index_i][2] <= coord_z_i;
      end
      if (cmd_i.start_setup) begin
        step_q <= '0;
        if (stat_o.long_curve) begin
          for (int ax = 0; ax < NUM_AXES; ax++) begin
            cur_q[ax] <= p0_diff[ax];
          end
        end
      end
      if (cmd_i.next_step) begin
        step_q <= step_sat;
        for (int ax = 0; ax < NUM_AXES; ax++) begin
          cur_q[ax] <= cur_nx[ax];
          d1_q[ax]  <= d1_q[ax] + d2_q[ax];
          d2_q[ax]  <= d2_q[ax] + d3_q[ax];
        end
      end
      if (cmd_i.div_wb) begin
        unique case (cmd_i.term)
          TERM_A:  d1_q[cmd_i.axis] <= quo_s;
          TERM_A6: begin
            d2_q[cmd_i.axis] <= quo_s;
            d3_q[cmd_i.axis] <= quo_s;
          end
          TERM_B:  d1_q[cmd_i.axis] <= d1_q[cmd_i.axis] + quo_s;
          TERM_B2: d2_q[cmd_i.axis] <= d2_q[cmd_i.axis] + quo_s;
          TERM_C:  d1_q[cmd_i.axis] <= d1_q[cmd_i.axis] + quo_s;
          default: ;
        endcase
      end
    end
  end

  // Setup arithmetic, the restoring divider and the output registers; payload only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_setup) begin
      m_q <= steps_q - 1'b1;
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        logic signed [COEF_W-1:0] p0, p1, p2, p3;
        p0 = COEF_W'(cp_q[0][ax]);
        p1 = COEF_W'(cp_q[1][ax]);
        p2 = COEF_W'(cp_q[2][ax]);
        p3 = COEF_W'(cp_q[3][ax]);
        ca_q[ax] <= -p0 + (p1 <<< 1) + p1 - (p2 <<< 1) - p2 + p3;
        cb_q[ax] <= (p0 <<< 1) + p0 - (p1 <<< 2) - (p1 <<< 1) + (p2 <<< 1) + p2;
        cc_q[ax] <= (p1 <<< 1) + p1 - (p0 <<< 1) - p0;
      end
    end
    if (cmd_i.mul_sq) begin
      m2_q <= (2*STEP_W)'(m_q) * (2*STEP_W)'(m_q);
    end
    if (cmd_i.mul_cube) begin
      m3_q <= DIFF_W'(m2_q) * DIFF_W'(m_q);
    end
    if (cmd_i.div_load) begin
      neg_q <= numer[COEF_W-1];
      dvd_q <= DVD_W'(numer_mag[MAG_W-1:0]) << SHIFT_UP;
      rem_q <= '0;
      quo_q <= '0;
      unique case (cmd_i.term)
        TERM_A, TERM_A6: dsr_q <= DSR_W'(m3_q) << SHIFT_DOWN;
        TERM_B, TERM_B2: dsr_q <= DSR_W'(m2_q) << SHIFT_DOWN;
        default:         dsr_q <= DSR_W'(m_q) << SHIFT_DOWN;
      endcase
    end
    if (cmd_i.div_step) begin
      dvd_q <= dvd_q << 1;
      quo_q <= {quo_q[DIFF_W-2:0], trial_ok};
      rem_q <= trial_ok ? (trial - REM_W'(dsr_q)) : trial;
    end
    if (cmd_i.emit) begin
      pos_x_o      <= to_coord(emit_pt[0]);
      pos_y_o      <= to_coord(emit_pt[1]);
      pos_z_o      <= to_coord(emit_pt[2]);
      curve_done_o <= (emit_step >= steps_q);
    end
  end

endmodule

### test/cbfd_checker.sv
// ----------------------------------------------------------------------------
// cbfd_checker
// Watches the command and point channels of the curve stepper, keeps its own
// copy of the curve state, predicts every point and compares field by field.
// ----------------------------------------------------------------------------
module cbfd_checker
  import cbfd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [STEP_W-1:0] cfg_wdata_i,
  cbfd_in_if                in_ch,
  cbfd_out_if               out_ch,
  output int                fail_count,
  output int                points_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int UP = DIFF_FRAC_BITS_DEF - COORD_FRAC_BITS_DEF;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      done;
  } curve_point_t;

  curve_point_t              points_due[$];
  logic [STEP_W-1:0]         steps_wanted;
  logic [STEP_W-1:0]         step_count;
  logic signed [COORD_W-1:0] ctrl_pt[NUM_PTS][NUM_AXES];
  logic signed [DIFF_W-1:0]  cur_pt[NUM_AXES];
  logic signed [DIFF_W-1:0]  d1[NUM_AXES];
  logic signed [DIFF_W-1:0]  d2[NUM_AXES];
  logic signed [DIFF_W-1:0]  d3[NUM_AXES];

  assign points_pending = points_due.size();

  // Scaled quotient, truncated toward zero.
  function automatic longint scaled_quot(longint v, longint unsigned d);
    bit [127:0] mag;
    bit [127:0] q;
    mag = (v < 0) ? 128'(-v) : 128'(v);
    q = (mag << UP) / 128'(d);
    return (v < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  task automatic setup_curve();
    longint unsigned m;
    longint p0, p1, p2, p3, a, b, c, t6a;
    step_count = '0;
    if (steps_wanted <= 1) return;
    m = steps_wanted - 1;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      p0 = ctrl_pt[0][ax];
      p1 = ctrl_pt[1][ax];
      p2 = ctrl_pt[2][ax];
      p3 = ctrl_pt[3][ax];
      a = -p0 + 3 * p1 - 3 * p2 + p3;
      b = 3 * p0 - 6 * p1 + 3 * p2;
      c = 3 * p1 - 3 * p0;
      t6a = scaled_quot(6 * a, m * m * m);
      cur_pt[ax] = DIFF_W'(p0 <<< UP);
      d1[ax] = DIFF_W'(scaled_quot(a, m * m * m) + scaled_quot(b, m * m)
                       + scaled_quot(c, m));
      d2[ax] = DIFF_W'(t6a + scaled_quot(2 * b, m * m));
      d3[ax] = DIFF_W'(t6a);
    end
  endtask

  task automatic advance_curve();
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      cur_pt[ax] = cur_pt[ax] + d1[ax];
      d1[ax] = d1[ax] + d2[ax];
      d2[ax] = d2[ax] + d3[ax];
    end
    if (step_count != '1) step_count++;
  endtask

  task automatic queue_point();
    curve_point_t p;
    p.x = cur_pt[0][DIFF_W-1:UP];
    p.y = cur_pt[1][DIFF_W-1:UP];
    p.z = cur_pt[2][DIFF_W-1:UP];
    p.done = (step_count >= steps_wanted);
    points_due.push_back(p);
  endtask

  task automatic compare_point();
    curve_point_t p;
    if (points_due.size() == 0) begin
      $error("point transaction with none expected");
      fail_count++;
      return;
    end
    p = points_due.pop_front();
    if (out_ch.pos_x !== p.x) begin
      $error("pos_x expected %0d actual %0d", p.x, out_ch.pos_x);
      fail_count++;
    end
    if (out_ch.pos_y !== p.y) begin
      $error("pos_y expected %0d actual %0d", p.y, out_ch.pos_y);
      fail_count++;
    end
    if (out_ch.pos_z !== p.z) begin
      $error("pos_z expected %0d actual %0d", p.z, out_ch.pos_z);
      fail_count++;
    end
    if (out_ch.curve_done !== p.done) begin
      $error("curve_done expected %0d actual %0d", p.done, out_ch.curve_done);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_count = 0;
      steps_wanted = '0;
      step_count = '0;
      points_due.delete();
      for (int i = 0; i < NUM_PTS; i++)
        for (int ax = 0; ax < NUM_AXES; ax++) ctrl_pt[i][ax] = '0;
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        cur_pt[ax] = '0;
        d1[ax] = '0;
        d2[ax] = '0;
        d3[ax] = '0;
      end
    end else begin
      if (out_ch.valid && out_ch.ready) compare_point();
      if (cfg_we_i) steps_wanted = cfg_wdata_i;
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.func)
          FUNC_LOAD: begin
            ctrl_pt[in_ch.point_index][0] = in_ch.coord_x;
            ctrl_pt[in_ch.point_index][1] = in_ch.coord_y;
            ctrl_pt[in_ch.point_index][2] = in_ch.coord_z;
          end
          FUNC_START: begin
            setup_curve();
            queue_point();
          end
          FUNC_NEXT: begin
            advance_curve();
            queue_point();
          end
          default: ;
        endcase
      end
    end
  end

endmodule

### test/cubic_bezier_forward_difference_tb.sv
// ----------------------------------------------------------------------------
// cubic_bezier_forward_difference_tb
// Drives control point loads, curve starts and steps under several step
// counts with random stalls on both channels; a checker predicts each point.
// ----------------------------------------------------------------------------
module cubic_bezier_forward_difference_tb;
  import cbfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 20;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [STEP_W-1:0] cfg_wdata_i;
  int                fail_count;
  int                points_pending;
  int                quiet_cycles;
  bit                idling_on;
  bit                hold_request;

  cbfd_in_if  cmd_ch ();
  cbfd_out_if pt_ch ();

  cubic_bezier_forward_difference dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (cmd_ch),
    .out_o      (pt_ch)
  );

  cbfd_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_ch         (cmd_ch),
    .out_ch        (pt_ch),
    .fail_count    (fail_count),
    .points_pending(points_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on cycles in which neither channel moves a transaction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((cmd_ch.valid && cmd_ch.ready) || (pt_ch.valid && pt_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: random short stalls, and one long hold when asked.
  initial begin
    pt_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        pt_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        pt_ch.ready <= 1'b1;
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        pt_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        pt_ch.ready <= 1'b1;
      end else begin
        pt_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_cmd(logic [FUNC_W-1:0] func, logic [PT_W-1:0] pt,
                          logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.func        <= func;
    cmd_ch.point_index <= pt;
    cmd_ch.coord_x     <= x;
    cmd_ch.coord_y     <= y;
    cmd_ch.coord_z     <= z;
    do @(posedge clk_i); while (!cmd_ch.ready);
  endtask

  task automatic quiesce();
    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (points_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_steps(logic [STEP_W-1:0] v);
    quiesce();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      1:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_curve(int unsigned steps);
    int unsigned n_next;
    for (int i = 0; i < NUM_PTS; i++) begin
      if ($urandom_range(0, 4) != 0)
        send_cmd(FUNC_LOAD, PT_W'(i), rand_coord(), rand_coord(), rand_coord());
    end
    if ($urandom_range(0, 5) == 0)
      send_cmd(FUNC_UNUSED, PT_W'($urandom), $urandom, $urandom, $urandom);
    send_cmd(FUNC_START, PT_W'($urandom), $urandom, $urandom, $urandom);
    n_next = $urandom_range(1, (steps + 2 > 30) ? 30 : steps + 2);
    for (int i = 0; i < n_next; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_cmd(FUNC_W'($urandom), PT_W'($urandom), rand_coord(), rand_coord(),
                 rand_coord());
      else
        send_cmd(FUNC_NEXT, PT_W'($urandom), $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    int unsigned setting[8];
    int unsigned total;

    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.func        = FUNC_LOAD;
    cmd_ch.point_index = '0;
    cmd_ch.coord_x     = '0;
    cmd_ch.coord_y     = '0;
    cmd_ch.coord_z     = '0;
    idling_on          = 1'b1;
    hold_request       = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a short curve leaves the point alone, unused code is dropped.
    send_cmd(FUNC_START, 2'd0, '0, '0, '0);
    send_cmd(FUNC_NEXT, 2'd0, '0, '0, '0);
    send_cmd(FUNC_UNUSED, 2'd3, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_cmd(FUNC_LOAD, 2'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
    send_cmd(FUNC_LOAD, 2'd1, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    send_cmd(FUNC_LOAD, 2'd2, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000);
    send_cmd(FUNC_LOAD, 2'd3, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_0000);
    set_steps(16'd4);
    send_cmd(FUNC_START, 2'd0, '0, '0, '0);
    repeat (5) send_cmd(FUNC_NEXT, 2'd0, '0, '0, '0);
    set_steps(16'd1);
    send_cmd(FUNC_START, 2'd0, '0, '0, '0);
    send_cmd(FUNC_NEXT, 2'd0, '0, '0, '0);
    set_steps(16'd2);
    send_cmd(FUNC_START, 2'd0, '0, '0, '0);
    repeat (2) send_cmd(FUNC_NEXT, 2'd0, '0, '0, '0);

    // Random curves under a spread of step counts.
    setting = '{2, 3, 5, 17, 0, 1, 65535, 100};
    total = 0;
    for (int s = 0; total < 700; s = (s + 1) % 8) begin
      set_steps((s == 7) ? 16'($urandom_range(2, 200)) : 16'(setting[s]));
      for (int k = 0; k < 6; k++) begin
        if (s == 3 && k == 1 && total < 300) hold_request = 1'b1;
        random_curve(setting[s]);
        total += 12;
      end
    end

    // Last part without idling: a long curve stepped back to back.
    idling_on = 1'b0;
    set_steps(16'hffff);
    send_cmd(FUNC_START, 2'd0, '0, '0, '0);
    repeat (40) send_cmd(FUNC_NEXT, 2'd0, '0, '0, '0);
    quiesce();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
